// File: rtl/core/sfhs_pkg.sv
// shared types, constants and the fnv-1a byte step for the subsampled frame hash
// no dependencies
package sfhs_pkg;

  localparam int DEF_SAMPLE_STRIDE = 8;
  localparam int DEF_MAX_DIM       = 4096;

  localparam int DIM_REG_W = 13;
  localparam int DUR_W     = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int HASH_W    = 64;
  localparam int PIXEL_W   = 32;
  localparam int OP_W      = 2;

  localparam logic [OP_W-1:0] OP_PIXEL   = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK    = 2'd1;
  localparam logic [OP_W-1:0] OP_REQUEST = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STABLE_DURATION = 2'd2;

  localparam logic [DIM_REG_W-1:0] RST_FRAME_WIDTH     = 13'd1920;
  localparam logic [DIM_REG_W-1:0] RST_FRAME_HEIGHT    = 13'd1080;
  localparam logic [DUR_W-1:0]     RST_STABLE_DURATION = 16'd1000;

  localparam logic [HASH_W-1:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;

  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [PIXEL_W-1:0] pixel;
  } in_t;

  typedef struct packed {
    logic [HASH_W-1:0] frame_hash;
    logic              frame_done;
    logic              stable;
    logic              became_stable;
  } out_t;

  typedef struct packed {
    logic       load;
    logic       step;
    logic [1:0] byte_sel;
    logic       commit;
  } cmd_t;

  typedef struct packed {
    logic sample_in;
  } stat_t;

  // xor one byte, then multiply by the prime 2^40 + 2^8 + 0xb3 as shifted adds
  function automatic logic [HASH_W-1:0] fnv_byte(input logic [HASH_W-1:0] h,
                                                 input logic [7:0] b);
    logic [HASH_W-1:0] x;
    x = h ^ {{(HASH_W-8){1'b0}}, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

// File: rtl/core/sfhs_ctrl.sv
// controller: accepts a request, steps the hash over four bytes for a sampled pixel, commits the result
// depends on sfhs_pkg
module sfhs_ctrl
  import sfhs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [1:0] {S_IDLE, S_HASH, S_FIN} state_t;

  state_t     state;
  logic [1:0] bsel;

  always_comb begin
    in_ready     = (state == S_IDLE);
    cmd.load     = in_valid && in_ready;
    cmd.step     = (state == S_HASH);
    cmd.byte_sel = bsel;
    cmd.commit   = (state == S_FIN) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      bsel      <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          bsel <= 2'd0;
          if (cmd.load) begin
            state <= stat.sample_in ? S_HASH : S_FIN;
          end
        end
        S_HASH: begin
          bsel <= bsel + 2'd1;
          if (bsel == 2'd3) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (cmd.commit) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/core/sfhs_dp.sv
// datapath: config registers, raster counters, running hash and stability tracking
// depends on sfhs_pkg
module sfhs_dp
  import sfhs_pkg::*;
#(
  parameter int SAMPLE_STRIDE = DEF_SAMPLE_STRIDE,
  parameter int MAX_DIM       = DEF_MAX_DIM
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  in_t                  in_data,
  input  cmd_t                 cmd,
  output stat_t                stat,
  output out_t                 out_data
);

  localparam int CW  = $clog2(MAX_DIM);
  localparam int MW  = $clog2(MAX_DIM + 1);
  localparam int EW  = (MW > DIM_REG_W) ? MW : DIM_REG_W;
  localparam int SW  = (SAMPLE_STRIDE > 1) ? $clog2(SAMPLE_STRIDE) : 1;
  localparam logic [SW-1:0] PH_LAST = SW'(SAMPLE_STRIDE - 1);
  localparam logic [EW-1:0] DIM_MAX = EW'(MAX_DIM);

  logic [DIM_REG_W-1:0] frame_width, frame_height;
  logic [DUR_W-1:0]     stable_duration;

  logic [OP_W-1:0]    op_r;
  logic [PIXEL_W-1:0] pix_r;

  logic [HASH_W-1:0] running_hash, previous_hash, last_frame_hash;
  logic [CW-1:0]     column_count, row_count;
  logic [SW-1:0]     col_phase, row_phase;
  logic [DUR_W-1:0]  quiet_elapsed;
  logic              request_pending, stable_flag, seen_frame;

  logic [HASH_W-1:0] running_hash_next, previous_hash_next, last_frame_hash_next;
  logic [CW-1:0]     column_count_next, row_count_next;
  logic [SW-1:0]     col_phase_next, row_phase_next;
  logic [DUR_W-1:0]  quiet_elapsed_next;
  logic              request_pending_next, stable_flag_next, seen_frame_next;
  out_t              out_next;

  logic [EW-1:0]     w_eff, h_eff;
  logic              col_end, row_end;
  logic              do_check;
  logic [HASH_W-1:0] cmp_hash;
  logic [DUR_W-1:0]  q_base;

  function automatic logic [EW-1:0] eff_dim(input logic [DIM_REG_W-1:0] v);
    logic [EW-1:0] ve;
    ve = EW'(v);
    if (v == '0) return EW'(1);
    if (ve > DIM_MAX) return DIM_MAX;
    return ve;
  endfunction

  assign stat.sample_in = (in_data.opcode == OP_PIXEL) && (col_phase == '0)
                          && (row_phase == '0);

  always_comb begin
    w_eff   = eff_dim(frame_width);
    h_eff   = eff_dim(frame_height);
    col_end = ((EW+1)'(column_count) + (EW+1)'(1)) >= (EW+1)'(w_eff);
    row_end = ((EW+1)'(row_count) + (EW+1)'(1)) >= (EW+1)'(h_eff);

    running_hash_next    = running_hash;
    previous_hash_next   = previous_hash;
    last_frame_hash_next = last_frame_hash;
    column_count_next    = column_count;
    row_count_next       = row_count;
    col_phase_next       = col_phase;
    row_phase_next       = row_phase;
    quiet_elapsed_next   = quiet_elapsed;
    request_pending_next = request_pending;
    stable_flag_next     = stable_flag;
    seen_frame_next      = seen_frame;
    out_next             = '0;
    do_check             = 1'b0;
    cmp_hash             = last_frame_hash;
    q_base               = quiet_elapsed;

    case (op_r)
      OP_PIXEL: begin
        if (col_end) begin
          column_count_next = '0;
          col_phase_next    = '0;
          if (row_end) begin
            row_count_next       = '0;
            row_phase_next       = '0;
            out_next.frame_done  = 1'b1;
            out_next.frame_hash  = running_hash;
            last_frame_hash_next = running_hash;
            running_hash_next    = FNV_BASIS;
            seen_frame_next      = 1'b1;
            do_check             = request_pending;
            cmp_hash             = running_hash;
          end else begin
            row_count_next = row_count + CW'(1);
            row_phase_next = (row_phase == PH_LAST) ? '0 : row_phase + SW'(1);
          end
        end else begin
          column_count_next = column_count + CW'(1);
          col_phase_next    = (col_phase == PH_LAST) ? '0 : col_phase + SW'(1);
        end
      end
      OP_TICK: begin
        q_base             = (quiet_elapsed < stable_duration) ?
                             quiet_elapsed + DUR_W'(1) : stable_duration;
        quiet_elapsed_next = q_base;
        do_check           = request_pending && seen_frame;
      end
      OP_REQUEST: begin
        stable_flag_next     = 1'b0;
        request_pending_next = 1'b1;
        quiet_elapsed_next   = '0;
      end
      default: ;
    endcase

    if (do_check) begin
      if (cmp_hash != previous_hash) begin
        previous_hash_next = cmp_hash;
        quiet_elapsed_next = '0;
      end else if (q_base >= stable_duration) begin
        stable_flag_next       = 1'b1;
        request_pending_next   = 1'b0;
        out_next.became_stable = 1'b1;
      end
    end
    out_next.stable = stable_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width     <= RST_FRAME_WIDTH;
      frame_height    <= RST_FRAME_HEIGHT;
      stable_duration <= RST_STABLE_DURATION;
      running_hash    <= FNV_BASIS;
      previous_hash   <= '0;
      last_frame_hash <= '0;
      column_count    <= '0;
      row_count       <= '0;
      col_phase       <= '0;
      row_phase       <= '0;
      quiet_elapsed   <= '0;
      request_pending <= 1'b0;
      stable_flag     <= 1'b0;
      seen_frame      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FRAME_WIDTH:     frame_width     <= cfg_data[DIM_REG_W-1:0];
          CFG_FRAME_HEIGHT:    frame_height    <= cfg_data[DIM_REG_W-1:0];
          CFG_STABLE_DURATION: stable_duration <= cfg_data[DUR_W-1:0];
          default: ;
        endcase
      end
      if (cmd.step) begin
        running_hash <= fnv_byte(running_hash, pix_r[{cmd.byte_sel, 3'b000} +: 8]);
      end else if (cmd.commit) begin
        running_hash <= running_hash_next;
      end
      if (cmd.commit) begin
        previous_hash   <= previous_hash_next;
        last_frame_hash <= last_frame_hash_next;
        column_count    <= column_count_next;
        row_count       <= row_count_next;
        col_phase       <= col_phase_next;
        row_phase       <= row_phase_next;
        quiet_elapsed   <= quiet_elapsed_next;
        request_pending <= request_pending_next;
        stable_flag     <= stable_flag_next;
        seen_frame      <= seen_frame_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_data.opcode;
      pix_r <= in_data.pixel;
    end
    if (cmd.commit) begin
      out_data <= out_next;
    end
  end

endmodule

// File: rtl/core/subsampled_frame_hash_stability.sv
// top level: subsampled fnv-1a frame hash with stability detection
// result: after accept, a sampled pixel steps through S_HASH byte by byte
// (the shift-add multiply by the fnv prime), then S_FIN commits it to the output register once that is free
// a new request is accepted only in S_IDLE, after the previous result has been committed
// synchronous reset restores the default frame size and duration and clears the hash, counters and stability state
// depends on sfhs_pkg, sfhs_ctrl, sfhs_dp
module subsampled_frame_hash_stability
  import sfhs_pkg::*;
#(
  parameter int SAMPLE_STRIDE = DEF_SAMPLE_STRIDE,
  parameter int MAX_DIM       = DEF_MAX_DIM
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data
);

  cmd_t  cmd;
  stat_t stat;

  sfhs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sfhs_dp #(
    .SAMPLE_STRIDE (SAMPLE_STRIDE),
    .MAX_DIM       (MAX_DIM)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

// File: tb/sfhs_hash_check.sv
// result checker for the subsampled frame hash: tracks register writes, predicts
// every accepted request and compares each accepted result against the oldest prediction
// depends on sfhs_pkg
`timescale 1ns / 100ps
module sfhs_hash_check
  import sfhs_pkg::*;
#(
  parameter int SAMPLE_STRIDE = DEF_SAMPLE_STRIDE,
  parameter int MAX_DIM       = DEF_MAX_DIM
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  in_t                  in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  out_t                 out_data,
  output int                   mismatches,
  output int                   outstanding
);

  localparam logic [HASH_W-1:0] FNV_PRIME = 64'd1099511628211;

  logic [DIM_REG_W-1:0] width_reg;
  logic [DIM_REG_W-1:0] height_reg;
  logic [DUR_W-1:0]     duration_reg;
  logic [HASH_W-1:0]    running_hash;
  logic [HASH_W-1:0]    compare_hash;
  logic [HASH_W-1:0]    last_frame_hash;
  int unsigned          col;
  int unsigned          row;
  logic [DUR_W-1:0]     quiet_ms;
  logic                 request_pending;
  logic                 stable_flag;
  logic                 seen_frame;
  out_t                 expected_q[$];
  int                   err_count = 0;

  function automatic int unsigned clamp_dim(input logic [DIM_REG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function void reset_model();
    width_reg       = RST_FRAME_WIDTH;
    height_reg      = RST_FRAME_HEIGHT;
    duration_reg    = RST_STABLE_DURATION;
    running_hash    = FNV_BASIS;
    compare_hash    = '0;
    last_frame_hash = '0;
    col             = 0;
    row             = 0;
    quiet_ms        = '0;
    request_pending = 1'b0;
    stable_flag     = 1'b0;
    seen_frame      = 1'b0;
  endfunction

  // returns 1 when stability is declared
  function automatic logic compare_frame(input logic [HASH_W-1:0] h);
    if (h != compare_hash) begin
      compare_hash = h;
      quiet_ms     = '0;
      return 1'b0;
    end
    if (quiet_ms >= duration_reg) begin
      stable_flag     = 1'b1;
      request_pending = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic out_t hash_step(input in_t req);
    out_t        res;
    int unsigned w;
    int unsigned h;
    res = '0;
    case (req.opcode)
      OP_PIXEL: begin
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        if (col % SAMPLE_STRIDE == 0 && row % SAMPLE_STRIDE == 0) begin
          for (int b = 0; b < 4; b++)
            running_hash = (running_hash ^ {56'd0, req.pixel[8*b +: 8]}) * FNV_PRIME;
        end
        if (col + 1 >= w) begin
          col = 0;
          if (row + 1 >= h) begin
            row             = 0;
            res.frame_done  = 1'b1;
            res.frame_hash  = running_hash;
            last_frame_hash = running_hash;
            running_hash    = FNV_BASIS;
            seen_frame      = 1'b1;
            if (request_pending) res.became_stable = compare_frame(res.frame_hash);
          end else begin
            row++;
          end
        end else begin
          col++;
        end
      end
      OP_TICK: begin
        if (quiet_ms < duration_reg) quiet_ms++;
        else quiet_ms = duration_reg;
        if (request_pending && seen_frame) res.became_stable = compare_frame(last_frame_hash);
      end
      OP_REQUEST: begin
        stable_flag     = 1'b0;
        request_pending = 1'b1;
        quiet_ms        = '0;
      end
      default: ;
    endcase
    res.stable = stable_flag;
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input logic [HASH_W-1:0] want_v,
                               input logic [HASH_W-1:0] got_v);
    err_count++;
    $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want_v, got_v);
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      reset_model();
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FRAME_WIDTH:     width_reg = cfg_data[DIM_REG_W-1:0];
          CFG_FRAME_HEIGHT:    height_reg = cfg_data[DIM_REG_W-1:0];
          CFG_STABLE_DURATION: duration_reg = cfg_data[DUR_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          flag_mismatch("unexpected result", '0, out_data.frame_hash);
        end else begin
          want = expected_q.pop_front();
          if (out_data.frame_hash !== want.frame_hash)
            flag_mismatch("frame_hash", want.frame_hash, out_data.frame_hash);
          if (out_data.frame_done !== want.frame_done)
            flag_mismatch("frame_done", want.frame_done, out_data.frame_done);
          if (out_data.stable !== want.stable)
            flag_mismatch("stable", want.stable, out_data.stable);
          if (out_data.became_stable !== want.became_stable)
            flag_mismatch("became_stable", want.became_stable, out_data.became_stable);
        end
      end
      if (in_valid && in_ready) expected_q.push_back(hash_step(in_data));
    end
    mismatches  <= err_count;
    outstanding <= expected_q.size();
  end

endmodule

// File: tb/tb.sv
// top of the frame hash testbench: clock, reset, register writes, request stimulus
// and result back-pressure; the verdict comes from the mismatch and outstanding counts of sfhs_hash_check
// depends on sfhs_pkg, sfhs_hash_check and the subsampled_frame_hash_stability rtl
`timescale 1ns / 100ps
module tb;
  import sfhs_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1200;
  localparam int STALL_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam int TAIL_CYCLES  = 20;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  in_t                  in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_t                 out_data;
  int                   mismatches;
  int                   outstanding;
  int                   hold_asks = 0;
  int                   hold_done = 0;
  int                   stalled = 0;
  int                   random_items = 0;
  int                   frame_px;
  int                   pix_idx;
  logic [PIXEL_W-1:0]   scene;
  logic                 no_gaps;

  subsampled_frame_hash_stability dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  sfhs_hash_check hash_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int frame_dim(input logic [DIM_REG_W-1:0] v);
    if (v == 0) return 1;
    if (v > DEF_MAX_DIM) return DEF_MAX_DIM;
    return int'(v);
  endfunction

  task automatic send(input logic [OP_W-1:0] op, input logic [PIXEL_W-1:0] px);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{opcode: op, pixel: px};
    do @(posedge clk); while (!in_ready);
  endtask

  // pixels follow a scene pattern so frames repeat; a few are noise
  task automatic send_scene_pixel();
    logic [PIXEL_W-1:0] px;
    if ($urandom_range(0, 24) == 0) px = $urandom;
    else px = scene ^ (pix_idx * 32'h9E37_79B9);
    pix_idx++;
    if (pix_idx >= frame_px) begin
      pix_idx = 0;
      if ($urandom_range(0, 3) == 0) scene = $urandom;
    end
    send(OP_PIXEL, px);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                           input logic [CFG_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= CFG_FRAME_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_index <= CFG_STABLE_DURATION;
    cfg_data  <= d;
    @(posedge clk);
    cfg_we    <= 1'b0;
    frame_px = frame_dim(w[DIM_REG_W-1:0]) * frame_dim(h[DIM_REG_W-1:0]);
    pix_idx  = 0;
  endtask

  function automatic logic [CFG_W-1:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 6);
    if (r < 92) return $urandom_range(7, 24);
    if (r < 97) return 0;
    return $urandom_range(25, 64);
  endfunction

  function automatic logic [CFG_W-1:0] pick_duration();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return 0;
    if (r < 75) return $urandom_range(1, 6);
    if (r < 90) return $urandom_range(7, 40);
    if (r < 95) return 16'hFFFF;
    return $urandom;
  endfunction

  task automatic run_phase(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 68) begin
        send_scene_pixel();
        random_items++;
      end else if (r < 84) begin
        send(OP_TICK, $urandom);
        random_items++;
      end else if (r < 90) begin
        send(OP_REQUEST, $urandom);
        random_items++;
      end else if (r < 93) begin
        send(OP_UNUSED, $urandom);
      end else begin
        send(OP_PIXEL, $urandom);
        random_items++;
      end
    end
  endtask

  // result side back-pressure
  initial begin
    int n;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_done != hold_asks) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done++;
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        out_ready <= 1'b1;
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(40, 150)) @(posedge clk);
        else repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stalled <= 0;
    end else if (stalled == STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stalled <= stalled + 1;
    end
  end

  initial begin
    int phase_no;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    no_gaps  = 1'b0;
    frame_px = int'(RST_FRAME_WIDTH) * int'(RST_FRAME_HEIGHT);
    pix_idx  = 0;
    scene    = $urandom;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset sizes: request and tick before any frame, unused opcode, pixel extremes
    send(OP_REQUEST, $urandom);
    send(OP_TICK, $urandom);
    send(OP_UNUSED, 32'hFFFF_FFFF);
    send(OP_PIXEL, 32'h0000_0000);
    send(OP_PIXEL, 32'hFFFF_FFFF);
    send(OP_TICK, 32'h0000_0000);
    settle();

    // zero sizes act as one pixel frames, zero duration
    configure(16'd0, 16'd0, 16'd0);
    send(OP_PIXEL, 32'h0000_0000);
    send(OP_REQUEST, $urandom);
    send(OP_PIXEL, 32'h0000_0000);
    send(OP_PIXEL, 32'h0000_0000);
    send(OP_PIXEL, 32'hFFFF_FFFF);
    send(OP_REQUEST, $urandom);
    send(OP_TICK, $urandom);
    send(OP_TICK, $urandom);
    send(OP_UNUSED, $urandom);
    send(OP_TICK, $urandom);
    settle();

    // oversized width clamps, longest duration
    configure(16'hFFFF, 16'd1, 16'hFFFF);
    send(OP_REQUEST, $urandom);
    send(OP_PIXEL, 32'h0123_4567);
    send(OP_PIXEL, 32'h89AB_CDEF);
    send(OP_TICK, $urandom);
    send(OP_TICK, $urandom);
    for (int i = 0; i < 250; i++) begin
      send_scene_pixel();
      if (i % 64 == 0) send(OP_TICK, $urandom);
    end
    settle();

    // shrinking mid-frame, then oversized height with one pixel rows
    configure(16'd1, 16'h1FFF, 16'd3);
    send(OP_REQUEST, $urandom);
    for (int i = 0; i < 250; i++) begin
      send_scene_pixel();
      if (i % 64 == 0) send(OP_TICK, $urandom);
    end
    settle();

    phase_no = 0;
    while (random_items < RANDOM_ITEMS) begin
      configure(pick_size(), pick_size(), pick_duration());
      no_gaps = ($urandom_range(0, 3) == 0);
      if (phase_no == 2) begin
        no_gaps = 1'b1;
        hold_asks <= hold_asks + 1;
        run_phase(300);
      end else begin
        run_phase($urandom_range(40, 220));
      end
      settle();
      phase_no++;
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
